/* hdl/sprite_quad_vertex_transform_core_macros.svh */
// Assertion macros used by the RTL file sprite_quad_vertex_transform_core.sv.
`ifndef SPRITE_QUAD_VERTEX_TRANSFORM_CORE_MACROS_SVH
`define SPRITE_QUAD_VERTEX_TRANSFORM_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SQVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SQVT_ASSERT_IMP(lbl, ante, cons, msg) \
  `SQVT_ASSERT(lbl, (ante) |-> (cons), msg)
`define SQVT_ASSERT_NXT(lbl, ante, cons, msg) \
  `SQVT_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define SQVT_ASSERT(lbl, prop, msg)
`define SQVT_ASSERT_IMP(lbl, ante, cons, msg)
`define SQVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/sqvt_pkg.sv */
package sqvt_pkg;

  localparam int SIN_ENTRIES = 1024;
  localparam int SIN_IDX_W   = $clog2(SIN_ENTRIES);
  localparam int QTR_W       = SIN_IDX_W - 2;
  localparam int QTR_STEPS   = SIN_ENTRIES / 4;
  localparam int ANG_SHIFT   = 16 - SIN_IDX_W;

  localparam int POS_W   = 20;
  localparam int DX_W    = 22;
  localparam int TRIG_W  = 16;
  localparam int COEF_W  = 17;
  localparam int ACC_W   = 38;
  localparam int PROD_W  = ACC_W + COEF_W;

  localparam int Q8_MAX = 524287;
  localparam int Q8_MIN = -524288;
  localparam logic [15:0] MAX_BATCH_RESET = 16'd2000;
  localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(16384);

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
  } mac_ctrl_t;

  typedef logic [TRIG_W-2:0] sin_lut_t [QTR_STEPS];

  // Quarter-wave sine in Q1.14 from the odd ninth-order polynomial.
  function automatic sin_lut_t gen_sin_lut();
    sin_lut_t   t;
    logic [63:0] z, z2, p, s;
    for (int j = 0; j < QTR_STEPS; j++) begin
      z  = 64'(j) << ANG_SHIFT;
      z2 = (z * z) >> 14;
      p  = 64'd172272;
      p  = 64'd5026994    - ((p * z2) >> 14);
      p  = 64'd85569306   - ((p * z2) >> 14);
      p  = 64'd693598668  - ((p * z2) >> 14);
      p  = 64'd1686629713 - ((p * z2) >> 14);
      s  = (p * z) >> 30;
      if (j == 0) s = 64'd0;
      if (s > 64'd16384) s = 64'd16384;
      t[j] = s[TRIG_W-2:0];
    end
    return t;
  endfunction

  localparam sin_lut_t SIN_LUT = gen_sin_lut();

  function automatic logic signed [TRIG_W-1:0] trig_lookup(logic [1:0] quad,
                                                          logic [QTR_W-1:0] k);
    logic [TRIG_W-1:0] mag;
    logic [QTR_W-1:0]  j;
    j = QTR_W'(0) - k;
    if (quad[0]) begin
      mag = (k == '0) ? TRIG_ONE : {1'b0, SIN_LUT[j]};
    end else begin
      mag = {1'b0, SIN_LUT[k]};
    end
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* hdl/sqvt_mac.sv */
module sqvt_mac import sqvt_pkg::*; (
  input  mac_ctrl_t                  ctrl_i,
  input  logic signed [ACC_W-1:0]    a_i,
  input  logic signed [COEF_W-1:0]   b_i,
  input  logic signed [ACC_W-1:0]    acc_i,
  output logic signed [PROD_W-1:0]   res_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] accx;

  assign prod = PROD_W'(a_i) * PROD_W'(b_i);
  assign accx = PROD_W'(acc_i);

  always_comb begin
    unique case (ctrl_i.op)
      OP_MUL:  res_o = prod;
      OP_ADD:  res_o = accx + prod;
      OP_SUB:  res_o = accx - prod;
      default: res_o = prod;
    endcase
  end

endmodule

/* hdl/sprite_quad_vertex_transform_core.sv */
// Channel  | Handshake              | Payload
// input    | in_valid_i/in_stall_o  | frame_start_i .. color_i, one sprite per item
// output   | out_valid_o/out_stall_i| vertex_x_o .. last_o, four items per sprite
// config   | cfg_we_i               | cfg_wdata_i (max_batch_sprites)
//
// After a sprite is accepted, S_LOAD reads the sine table and forms the corner offsets; then,
// for each corner, S_CALC runs its steps on the shared multiplier and S_EMIT loads the output
// register. The sequencer then returns to S_IDLE, the only state in which a new item is accepted.
// Reset is asynchronous and active low; it clears the batch state and loads
// max_batch_sprites with 2000. An output stall holds the sequencer at the
// load of the next corner; no new item is taken until the fourth corner is loaded.
`include "sprite_quad_vertex_transform_core_macros.svh"

module sprite_quad_vertex_transform_core import sqvt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [15:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    frame_start_i,
  input  logic [15:0]             texture_id_i,
  input  logic [11:0]             tex_width_i,
  input  logic [11:0]             tex_height_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] origin_x_i,
  input  logic signed [POS_W-1:0] origin_y_i,
  input  logic [15:0]             rotation_i,
  input  logic [15:0]             scale_i,
  input  logic [31:0]             color_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] vertex_x_o,
  output logic signed [POS_W-1:0] vertex_y_o,
  output logic [31:0]             vertex_color_o,
  output logic                    tex_u_o,
  output logic                    tex_v_o,
  output logic                    batch_start_o,
  output logic                    last_o
);

  localparam int FRAC_DROP = 26;
  localparam int SUM_W     = 32;
  localparam logic signed [PROD_W:0]  RoundBias = (PROD_W+1)'(2**(FRAC_DROP-1));
  localparam logic signed [SUM_W-1:0] PosMax    = SUM_W'(Q8_MAX);
  localparam logic signed [SUM_W-1:0] PosMin    = SUM_W'(Q8_MIN);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_CALC = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] corner_q, corner_d;

  logic [15:0] max_batch_q;
  logic [15:0] batch_tex_q;
  logic [15:0] batch_cnt_q;
  logic        batch_open_q;

  logic        fresh_q;
  logic [11:0] w_q, h_q;
  logic signed [POS_W-1:0] px_q, py_q, ox_q, oy_q;
  logic [15:0] rot_q, sc_q;
  logic [31:0] color_q;

  logic signed [TRIG_W-1:0] sn_q, cs_q;
  logic signed [DX_W-1:0]   dx0_q, dx1_q, dy0_q, dy1_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] tx_q, ty_q;

  logic        out_valid_q;
  logic signed [POS_W-1:0] vx_q, vy_q;
  logic [31:0] vcol_q;
  logic        u_q, v_q, bs_q, last_q;

  logic        accept;
  logic        emit_go;
  logic        fresh;
  logic [15:0] limit;
  logic        cu, cv;
  logic signed [DX_W-1:0]   dx, dy;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  mac_a;
  logic signed [COEF_W-1:0] mac_b;
  logic signed [PROD_W-1:0] mac_res;

  function automatic logic signed [POS_W-1:0] place(logic signed [PROD_W-1:0] t,
                                                    logic signed [POS_W-1:0] pos);
    logic signed [PROD_W:0]  tr;
    logic signed [SUM_W-1:0] sum;
    tr  = (PROD_W+1)'(t) + RoundBias;
    sum = SUM_W'($signed(tr[PROD_W:FRAC_DROP])) + SUM_W'(pos);
    if (sum > PosMax) sum = PosMax;
    if (sum < PosMin) sum = PosMin;
    return sum[POS_W-1:0];
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  assign limit = (max_batch_q == '0) ? 16'd1 : max_batch_q;
  assign fresh = frame_start_i || !batch_open_q || (texture_id_i != batch_tex_q) ||
                 (batch_cnt_q >= limit);

  // Corners run clockwise from top-left, so u is set on the middle two.
  assign cu = (corner_q == 2'd1) || (corner_q == 2'd2);
  assign cv = corner_q[1];
  assign dx = cu ? dx1_q : dx0_q;
  assign dy = cv ? dy1_q : dy0_q;

  always_comb begin
    mac_ctrl.op = OP_MUL;
    mac_a       = ACC_W'(dx);
    mac_b       = COEF_W'(cs_q);
    case (step_q)
      3'd0: begin
        mac_a = ACC_W'(dx);
        mac_b = COEF_W'(cs_q);
      end
      3'd1: begin
        mac_ctrl.op = OP_SUB;
        mac_a       = ACC_W'(dy);
        mac_b       = COEF_W'(sn_q);
      end
      3'd2, 3'd5: begin
        mac_a = acc_q;
        mac_b = $signed({1'b0, sc_q});
      end
      3'd3: begin
        mac_a = ACC_W'(dx);
        mac_b = COEF_W'(sn_q);
      end
      3'd4: begin
        mac_ctrl.op = OP_ADD;
        mac_a       = ACC_W'(dy);
        mac_b       = COEF_W'(cs_q);
      end
      default: ;
    endcase
  end

  sqvt_mac u_mac (
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_i  (acc_q),
    .res_o  (mac_res)
  );

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    corner_d = corner_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d  = S_CALC;
        step_d   = 3'd0;
        corner_d = 2'd0;
      end
      S_CALC: begin
        if (step_q == 3'd5) begin
          state_d = S_EMIT;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          step_d = 3'd0;
          if (corner_q == 2'd3) begin
            state_d = S_IDLE;
          end else begin
            state_d  = S_CALC;
            corner_d = corner_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= 3'd0;
      corner_q     <= 2'd0;
      max_batch_q  <= MAX_BATCH_RESET;
      batch_tex_q  <= '0;
      batch_cnt_q  <= '0;
      batch_open_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      corner_q <= corner_d;
      if (cfg_we_i) max_batch_q <= cfg_wdata_i;
      if (accept) begin
        batch_open_q <= 1'b1;
        if (fresh) begin
          batch_tex_q <= texture_id_i;
          batch_cnt_q <= 16'd1;
        end else begin
          batch_cnt_q <= batch_cnt_q + 16'd1;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fresh_q <= fresh;
      w_q     <= tex_width_i;
      h_q     <= tex_height_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      rot_q   <= rotation_i;
      sc_q    <= scale_i;
      color_q <= color_i;
    end
    if (state_q == S_LOAD) begin
      // The angle is truncated to the table grid; the cosine is a quarter turn on.
      sn_q  <= trig_lookup(rot_q[15:14], rot_q[13 -: QTR_W]);
      cs_q  <= trig_lookup(rot_q[15:14] + 2'd1, rot_q[13 -: QTR_W]);
      dx0_q <= DX_W'(0) - DX_W'(ox_q);
      dx1_q <= $signed({2'b00, w_q, 8'h00}) - DX_W'(ox_q);
      dy0_q <= DX_W'(0) - DX_W'(oy_q);
      dy1_q <= $signed({2'b00, h_q, 8'h00}) - DX_W'(oy_q);
    end
    if (state_q == S_CALC) begin
      case (step_q)
        3'd2:    tx_q  <= mac_res;
        3'd5:    ty_q  <= mac_res;
        default: acc_q <= mac_res[ACC_W-1:0];
      endcase
    end
    if (emit_go) begin
      vx_q   <= place(tx_q, px_q);
      vy_q   <= place(ty_q, py_q);
      vcol_q <= color_q;
      u_q    <= cu;
      v_q    <= cv;
      bs_q   <= fresh_q && (corner_q == 2'd0);
      last_q <= (corner_q == 2'd3);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_x_o     = vx_q;
  assign vertex_y_o     = vy_q;
  assign vertex_color_o = vcol_q;
  assign tex_u_o        = u_q;
  assign tex_v_o        = v_q;
  assign batch_start_o  = bs_q;
  assign last_o         = last_q;

  `SQVT_ASSERT_IMP(a_open_count, batch_open_q, batch_cnt_q != 16'd0, "open batch with no sprite")
  `SQVT_ASSERT_IMP(a_step_range, state_q == S_CALC, step_q <= 3'd5, "sequencer step out of range")
  `SQVT_ASSERT_IMP(a_bs_corner0, out_valid_o && batch_start_o, !tex_u_o && !tex_v_o,
                   "batch start flagged away from the first corner")
  `SQVT_ASSERT_NXT(a_last_idle, emit_go && (corner_q == 2'd3), state_q == S_IDLE && last_o,
                   "fourth corner did not end the item")

endmodule
